// File: rtl/core/radix_tree_next_hop_defines.svh
// Assertion macros used by the checker file.
`ifndef RADIX_TREE_NEXT_HOP_DEFINES_SVH
`define RADIX_TREE_NEXT_HOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define RTNH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define RTNH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rtnh_pkg.sv
package rtnh_pkg;

    // Width of level starts, level sizes and remainders; values saturate at all ones
    localparam int VW = 18;
    // Quotient bits of the wide remainder pass (dividend below 2**16)
    localparam int WIDE_STEPS = 16;
    // Width of the shifted divisor in the remainder unit
    localparam int DW = VW + WIDE_STEPS - 1;
    // Step counter width of the remainder unit
    localparam int CW = 5;
    // Level index width (at most 18 levels are walked)
    localparam int LVL_W = 5;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 17;
    localparam logic [CFG_AW-1:0] REG_MY_RANK  = 4'd0;
    localparam logic [CFG_AW-1:0] REG_FANOUT   = 4'd1;
    localparam logic [CFG_AW-1:0] REG_NODE_CNT = 4'd2;
    localparam logic [CFG_AW-1:0] REG_LIFELINE = 4'd3;

    // Route kinds
    localparam logic [2:0] KIND_WILDCARD = 3'd0;
    localparam logic [2:0] KIND_LIFELINE = 3'd1;
    localparam logic [2:0] KIND_SELF     = 3'd2;
    localparam logic [2:0] KIND_CHILD    = 3'd3;
    localparam logic [2:0] KIND_SUBTREE  = 3'd4;
    localparam logic [2:0] KIND_PARENT   = 3'd5;

    // Request to the remainder unit
    typedef struct packed {
        logic          start;
        logic          wide;
        logic [VW-1:0] dividend;
        logic [VW-1:0] divisor;
    } rtnh_mod_cmd_t;

endpackage

// File: rtl/core/rtnh_mod_unit.sv
module rtnh_mod_unit
    import rtnh_pkg::*;
#(
    parameter int NARROW_STEPS = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rtnh_mod_cmd_t cmd,
    output logic [VW-1:0] rem,
    output logic          done
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsh_reg, dsh_next;
    logic          fits;

    // Compare the remainder against the shifted divisor
    assign fits = {{(DW-VW){1'b0}}, rem_reg} >= dsh_reg;

    // Load a new request or run one restoring step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            rem_next  = cmd.dividend;
            if (cmd.wide) begin
                dsh_next = DW'(cmd.divisor) << (WIDE_STEPS - 1);
                cnt_next = CW'(WIDE_STEPS);
            end else begin
                dsh_next = DW'(cmd.divisor) << (NARROW_STEPS - 1);
                cnt_next = CW'(NARROW_STEPS);
            end
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg[VW-1:0];
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/radix_tree_next_hop.sv
// Next-hop lookup for a level-ordered k-ary tree of ranks.
// Configuration: cfg_valid/cfg_ready/cfg_addr/cfg_data writes my_rank (0), fanout (1),
// node_count (2) and lifeline_rank (3); cfg_ready is always high. Write only while idle.
// Requests enter on s_tvalid/s_tready: s_tdata = target_rank, s_tuser = target_special.
// Results leave on m_tvalid/m_tready: m_tdata = hop_rank, m_tuser = {route_kind, hop_valid}.
// One request is worked at a time; s_tready is low from acceptance until the result
// is loaded into the output register.
// The request walks the tree levels (2 to 18) needed to place both the target and
// my_rank, plus one level below my_rank, with one multiply-add per level; then come
// three remainder passes through one shared restoring unit (16 steps, then two of
// ceil(log2(MAX_FANOUT)) steps).
// A result waiting in the output register does not block the next request; if the
// receiver stalls, the finished next one holds in the last step until the register frees.
// Reset (synchronous, aresetn low) clears the sequencer and the output valid and loads
// my_rank 0, fanout 64, node_count 1, lifeline_rank 0.
module radix_tree_next_hop
    import rtnh_pkg::*;
#(
    parameter int MAX_NODES  = 65536,
    parameter int MAX_FANOUT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    // request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] target_rank
    input  logic [0:0]        s_tuser,   // [0] target_special
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] hop_rank
    output logic [3:0]        m_tuser    // [0] hop_valid, [3:1] route_kind
);

    localparam int KW = $clog2(MAX_FANOUT + 1);
    localparam int QB = (MAX_FANOUT > 2) ? $clog2(MAX_FANOUT) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_MODA  = 3'd3;
    localparam logic [2:0] ST_MODB  = 3'd4;
    localparam logic [2:0] ST_MODC  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic [VW-1:0] VMAX = {VW{1'b1}};

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VW] ? VMAX : s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] sat_mul(input logic [VW-1:0] a, input logic [KW-1:0] b);
        logic [VW+KW-1:0] p;
        p = (VW+KW)'(a) * (VW+KW)'(b);
        return (p[VW+KW-1:VW] != '0) ? VMAX : p[VW-1:0];
    endfunction

    // configuration registers
    logic [15:0]       my_rank_reg;
    logic [6:0]        fanout_reg;
    logic [16:0]       node_cnt_reg;
    logic [15:0]       lifeline_reg;

    // sequencer and request
    logic [2:0]        state_reg, state_next;
    logic [15:0]       tgt_reg, tgt_next;
    logic              special_reg, special_next;

    // level walk
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [VW-1:0]     start_reg, start_next;
    logic [VW-1:0]     size_reg, size_next;
    logic [VW-1:0]     p_start_reg, p_start_next;
    logic [VW-1:0]     p_size_reg, p_size_next;
    logic              my_found_reg, my_found_next;
    logic              tgt_found_reg, tgt_found_next;
    logic              nx_done_reg, nx_done_next;
    logic [LVL_W-1:0]  my_lvl_reg, my_lvl_next;
    logic [LVL_W-1:0]  tgt_lvl_reg, tgt_lvl_next;
    logic [VW-1:0]     my_start_reg, my_start_next;
    logic [VW-1:0]     my_size_reg, my_size_next;
    logic [VW-1:0]     myp_start_reg, myp_start_next;
    logic [VW-1:0]     myp_size_reg, myp_size_next;
    logic [VW-1:0]     nx_start_reg, nx_start_next;
    logic [VW-1:0]     nx_size_reg, nx_size_next;
    logic [VW-1:0]     tgt_start_reg, tgt_start_next;

    // remainders
    logic [VW-1:0]     r1_reg, r1_next;
    logic [VW-1:0]     r0_reg, r0_next;
    logic [VW-1:0]     rc_reg, rc_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_data_reg, m_data_next;
    logic [3:0]        m_user_reg, m_user_next;

    logic [KW-1:0]     k_eff;
    logic [VW-1:0]     my_v, tgt_v, end_w, size_mul, om;
    logic              my_hit, tgt_hit, in_range, found, have_parent;
    logic [VW-1:0]     child_sum, up_sum;
    logic [15:0]       hop_rank;
    logic              hop_valid;
    logic [2:0]        route_kind;
    rtnh_mod_cmd_t     mod_cmd;
    logic [VW-1:0]     mod_rem;
    logic              mod_done;

    rtnh_mod_unit #(
        .NARROW_STEPS(QB)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mod_cmd),
        .rem     (mod_rem),
        .done    (mod_done)
    );

    // Clamp the fanout to the supported range
    always_comb begin
        if (fanout_reg < 7'd2) begin
            k_eff = KW'(2);
        end else if (32'(fanout_reg) > MAX_FANOUT) begin
            k_eff = KW'(MAX_FANOUT);
        end else begin
            k_eff = KW'(fanout_reg);
        end
    end

    assign my_v     = VW'(my_rank_reg);
    assign tgt_v    = VW'(tgt_reg);
    assign end_w    = sat_add(start_reg, size_reg);
    assign size_mul = sat_mul(size_reg, k_eff);
    assign my_hit   = !my_found_reg && (my_v < end_w);
    assign tgt_hit  = !tgt_found_reg && (tgt_v < end_w);
    assign om       = my_v - my_start_reg;

    // Classify the request from the walk and remainder results
    assign in_range    = (32'(tgt_reg) < 32'(node_cnt_reg)) && (32'(tgt_reg) < MAX_NODES);
    assign found       = in_range && (tgt_lvl_reg > my_lvl_reg) && (r0_reg == om);
    assign have_parent = (my_rank_reg != 16'd0);
    assign child_sum   = nx_start_reg + r1_reg;
    assign up_sum      = myp_start_reg + rc_reg;

    always_comb begin
        hop_rank   = 16'd0;
        hop_valid  = 1'b0;
        route_kind = KIND_WILDCARD;
        if (special_reg) begin
            route_kind = KIND_WILDCARD;
        end else if (tgt_reg == lifeline_reg) begin
            route_kind = KIND_LIFELINE;
            if (have_parent) begin
                hop_rank  = up_sum[15:0];
                hop_valid = 1'b1;
            end
        end else if (tgt_reg == my_rank_reg) begin
            route_kind = KIND_SELF;
            hop_rank   = tgt_reg;
            hop_valid  = 1'b1;
        end else if (found) begin
            route_kind = (tgt_lvl_reg == my_lvl_reg + LVL_W'(1)) ? KIND_CHILD : KIND_SUBTREE;
            hop_rank   = child_sum[15:0];
            hop_valid  = 1'b1;
        end else begin
            route_kind = KIND_PARENT;
            if (have_parent) begin
                hop_rank  = up_sum[15:0];
                hop_valid = 1'b1;
            end
        end
    end

    // Sequencer: walk levels, then three remainder passes, then load the result
    always_comb begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        special_next   = special_reg;
        lvl_next       = lvl_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        p_start_next   = p_start_reg;
        p_size_next    = p_size_reg;
        my_found_next  = my_found_reg;
        tgt_found_next = tgt_found_reg;
        nx_done_next   = nx_done_reg;
        my_lvl_next    = my_lvl_reg;
        tgt_lvl_next   = tgt_lvl_reg;
        my_start_next  = my_start_reg;
        my_size_next   = my_size_reg;
        myp_start_next = myp_start_reg;
        myp_size_next  = myp_size_reg;
        nx_start_next  = nx_start_reg;
        nx_size_next   = nx_size_reg;
        tgt_start_next = tgt_start_reg;
        r1_next        = r1_reg;
        r0_next        = r0_reg;
        rc_next        = rc_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        mod_cmd        = '0;

        // drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tgt_next       = s_tdata;
                    special_next   = s_tuser[0];
                    lvl_next       = '0;
                    start_next     = '0;
                    size_next      = VW'(1);
                    p_start_next   = '0;
                    p_size_next    = VW'(1);
                    my_found_next  = 1'b0;
                    tgt_found_next = 1'b0;
                    nx_done_next   = 1'b0;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                // advance one level
                lvl_next     = lvl_reg + LVL_W'(1);
                start_next   = end_w;
                size_next    = size_mul;
                p_start_next = start_reg;
                p_size_next  = size_reg;
                if (my_hit) begin
                    my_found_next  = 1'b1;
                    my_lvl_next    = lvl_reg;
                    my_start_next  = start_reg;
                    my_size_next   = size_reg;
                    myp_start_next = p_start_reg;
                    myp_size_next  = p_size_reg;
                end
                // capture the level just below my_rank
                if (my_found_reg && !nx_done_reg) begin
                    nx_done_next  = 1'b1;
                    nx_start_next = start_reg;
                    nx_size_next  = size_reg;
                end
                if (tgt_hit) begin
                    tgt_found_next = 1'b1;
                    tgt_lvl_next   = lvl_reg;
                    tgt_start_next = start_reg;
                end
                if (my_found_reg && (tgt_found_reg || tgt_hit)) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // target offset modulo the size of the level below my_rank
                mod_cmd.start    = 1'b1;
                mod_cmd.wide     = 1'b1;
                mod_cmd.dividend = tgt_v - tgt_start_reg;
                mod_cmd.divisor  = nx_size_reg;
                state_next       = ST_MODA;
            end
            ST_MODA: begin
                if (mod_done) begin
                    r1_next          = mod_rem;
                    mod_cmd.start    = 1'b1;
                    mod_cmd.wide     = 1'b0;
                    mod_cmd.dividend = mod_rem;
                    mod_cmd.divisor  = my_size_reg;
                    state_next       = ST_MODB;
                end
            end
            ST_MODB: begin
                if (mod_done) begin
                    r0_next          = mod_rem;
                    mod_cmd.start    = 1'b1;
                    mod_cmd.wide     = 1'b0;
                    mod_cmd.dividend = om;
                    mod_cmd.divisor  = myp_size_reg;
                    state_next       = ST_MODC;
                end
            end
            ST_MODC: begin
                if (mod_done) begin
                    rc_next    = mod_rem;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hop_rank;
                    m_user_next  = {route_kind, hop_valid};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            my_found_reg  <= 1'b0;
            tgt_found_reg <= 1'b0;
            nx_done_reg   <= 1'b0;
            my_rank_reg   <= 16'd0;
            fanout_reg    <= 7'd64;
            node_cnt_reg  <= 17'd1;
            lifeline_reg  <= 16'd0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            my_found_reg  <= my_found_next;
            tgt_found_reg <= tgt_found_next;
            nx_done_reg   <= nx_done_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_MY_RANK:  my_rank_reg  <= cfg_data[15:0];
                    REG_FANOUT:   fanout_reg   <= cfg_data[6:0];
                    REG_NODE_CNT: node_cnt_reg <= cfg_data;
                    REG_LIFELINE: lifeline_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        tgt_reg       <= tgt_next;
        special_reg   <= special_next;
        lvl_reg       <= lvl_next;
        start_reg     <= start_next;
        size_reg      <= size_next;
        p_start_reg   <= p_start_next;
        p_size_reg    <= p_size_next;
        my_lvl_reg    <= my_lvl_next;
        tgt_lvl_reg   <= tgt_lvl_next;
        my_start_reg  <= my_start_next;
        my_size_reg   <= my_size_next;
        myp_start_reg <= myp_start_next;
        myp_size_reg  <= myp_size_next;
        nx_start_reg  <= nx_start_next;
        nx_size_reg   <= nx_size_next;
        tgt_start_reg <= tgt_start_next;
        r1_reg        <= r1_next;
        r0_reg        <= r0_next;
        rc_reg        <= rc_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

endmodule

// File: rtl/core/rtnh_checker.sv
`include "radix_tree_next_hop_defines.svh"

module rtnh_checker
    import rtnh_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // Hold a stalled result
    `RTNH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    `RTNH_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // One request at a time
    `RTNH_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // Invalid hop carries a zero rank
    `RTNH_ASSERT_IMP(a_zero_hop, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 16'd0, "invalid hop with nonzero rank")

    // Wildcard results never carry a hop
    `RTNH_ASSERT_IMP(a_wild_invalid, aclk, aresetn, m_tvalid && (m_tuser[3:1] == KIND_WILDCARD), !m_tuser[0], "wildcard result marked valid")

endmodule

bind radix_tree_next_hop rtnh_checker u_rtnh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
